>>> rtl/core/md5_pkg.sv
// shared types, constants and round functions of the md5 block hash
package md5_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned RoundCount = 64;
   localparam int unsigned BlockWords = 16;

   typedef logic [WordWidth-1:0] word_type;

   localparam word_type IV_A = 32'h67452301;
   localparam word_type IV_B = 32'hefcdab89;
   localparam word_type IV_C = 32'h98badcfe;
   localparam word_type IV_D = 32'h10325476;

   localparam word_type SINE_TABLE [RoundCount] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] SHIFT_TABLE [BlockWords] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // round phases, one per group of sixteen rounds
   localparam logic [1:0] PHASE_F = 2'd0;
   localparam logic [1:0] PHASE_G = 2'd1;
   localparam logic [1:0] PHASE_H = 2'd2;
   localparam logic [1:0] PHASE_I = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       store_word;  // write the accepted word into the buffer
      logic       reload_iv;   // first word of a message
      logic       init_work;   // load working words for a new compression
      logic       round_en;    // run one round
      logic [5:0] round;       // round number
      logic       add_back;    // add working words into chaining words
      logic [1:0] out_sel;     // digest word on the result port
   } md5_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic block_full;        // the offered word completes a block
   } md5_status_type;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [5:0] back;
      begin
         back = 6'd32 - {1'b0, n};
         rotl = (x << n) | (x >> back);
      end
   endfunction

   function automatic word_type round_mix(input logic [1:0] phase, input word_type b,
                                          input word_type c, input word_type d);
      begin
         unique case (phase)
            PHASE_F: round_mix = (b & c) | (~b & d);
            PHASE_G: round_mix = (d & b) | (~d & c);
            PHASE_H: round_mix = b ^ c ^ d;
            PHASE_I: round_mix = c ^ (b | ~d);
            default: round_mix = '0;
         endcase
      end
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] round);
      logic [3:0] r;
      begin
         r = round[3:0];
         unique case (round[5:4])
            PHASE_F: msg_index = r;
            PHASE_G: msg_index = 4'((r << 2) + r + 4'd1);
            PHASE_H: msg_index = 4'((r << 1) + r + 4'd5);
            PHASE_I: msg_index = 4'((r << 3) - r);
            default: msg_index = '0;
         endcase
      end
   endfunction

endpackage

>>> rtl/core/md5_block_hash.sv
// top level of the md5 block hash: word input, controller and datapath
// block: the transaction that completes a block starts the 64 rounds, one per
//   cycle, then the add-back state adds in; the first digest word is then offered in the emit state
// input: no new words are taken while a block is in its rounds, add-back or digest output,
//   as the single shared round unit serves every block; four result transactions after a final block
// reset: chaining words take the md5 initial values, block position goes to zero,
//   the controller waits for words; the block buffer is not cleared
module md5_block_hash (
   input  logic        clock,
   input  logic        reset,
   // message words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic        req_first_word,
   input  logic        req_final_block,
   // digest words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last
);

   md5_pkg::md5_cmd_type    cmd;
   md5_pkg::md5_status_type status;

   // controller: accepts words, sequences the 64 rounds and the digest output
   md5_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_word  (req_first_word),
      .req_final_block (req_final_block),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_last        (rsp_last),
      .status          (status),
      .cmd             (cmd)
   );

   // datapath: buffer of sixteen words, working words a to d, chaining words
   md5_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_message_word (req_message_word),
      .req_first_word   (req_first_word),
      .cmd              (cmd),
      .status           (status),
      .rsp_digest_word  (rsp_digest_word)
   );

   // digest word index follows the controller's output select
   assign rsp_word_index = cmd.out_sel;

endmodule

>>> rtl/core/md5_ctrl.sv
// controller state machine of the md5 block hash
module md5_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_first_word,
   input  logic                    req_final_block,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_last,
   input  md5_pkg::md5_status_type status,
   output md5_pkg::md5_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [1:0] idx_ff, idx_in;
   logic       final_ff, final_in;
   logic       req_take;
   logic       rsp_take;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_last  = (idx_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      final_in = final_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && status.block_full) begin
               final_in = req_final_block;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            idx_in   = '0;
            state_in = final_ff ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.store_word = req_take;
      cmd.reload_iv  = req_take && req_first_word;
      cmd.init_work  = req_take && status.block_full;
      cmd.round_en   = (state_ff == ST_ROUND);
      cmd.round      = round_ff;
      cmd.add_back   = (state_ff == ST_ADD);
      cmd.out_sel    = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         round_ff <= '0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         final_ff <= final_in;
      end
   end

endmodule

>>> rtl/core/md5_datapath.sv
// block buffer, chaining words and round datapath of the md5 block hash
module md5_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             req_message_word,
   input  logic                    req_first_word,
   input  md5_pkg::md5_cmd_type    cmd,
   output md5_pkg::md5_status_type status,
   output logic [31:0]             rsp_digest_word
);

   md5_pkg::word_type buf_ff [md5_pkg::BlockWords];
   md5_pkg::word_type chain_ff [4];
   md5_pkg::word_type chain_in [4];
   md5_pkg::word_type a_ff, b_ff, c_ff, d_ff;
   md5_pkg::word_type a_in, b_in, c_in, d_in;
   md5_pkg::word_type mix, sum_t;
   logic [4:0]        shift_amt;
   logic [3:0]        pos_ff, pos_in, pos_eff;
   logic              reload;

   // a first word restarts the block at position zero
   assign pos_eff           = req_first_word ? 4'd0 : pos_ff;
   assign status.block_full = (pos_eff == 4'd15);
   assign reload            = cmd.reload_iv;
   assign rsp_digest_word   = chain_ff[cmd.out_sel];

   assign mix   = md5_pkg::round_mix(cmd.round[5:4], b_ff, c_ff, d_ff);
   assign sum_t = mix + a_ff + md5_pkg::SINE_TABLE[cmd.round]
                + buf_ff[md5_pkg::msg_index(cmd.round)];

   // rotate amount picked by phase and by round within each group of four
   assign shift_amt = md5_pkg::SHIFT_TABLE[{cmd.round[5:4], cmd.round[1:0]}];

   always_comb begin
      pos_in = pos_ff;
      if (cmd.store_word) begin
         pos_in = pos_eff + 4'd1;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (reload) begin
         chain_in[0] = md5_pkg::IV_A;
         chain_in[1] = md5_pkg::IV_B;
         chain_in[2] = md5_pkg::IV_C;
         chain_in[3] = md5_pkg::IV_D;
      end else if (cmd.add_back) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.init_work) begin
         a_in = chain_in[0];
         b_in = chain_in[1];
         c_in = chain_in[2];
         d_in = chain_in[3];
      end else if (cmd.round_en) begin
         a_in = d_ff;
         d_in = c_ff;
         c_in = b_ff;
         b_in = b_ff + md5_pkg::rotl(sum_t, shift_amt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         chain_ff[0] <= md5_pkg::IV_A;
         chain_ff[1] <= md5_pkg::IV_B;
         chain_ff[2] <= md5_pkg::IV_C;
         chain_ff[3] <= md5_pkg::IV_D;
      end else begin
         pos_ff   <= pos_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      if (cmd.store_word) begin
         buf_ff[pos_eff] <= req_message_word;
      end
   end

endmodule

>>> verif/md5_block_hash_tb.sv
// md5_block_hash testbench: directed word table, then random messages against a predictor
module md5_block_hash_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ClockPeriod   = 10;
   localparam int ResetCycles   = 8;
   localparam int RandomWords   = 208;
   // 64 rounds, the add-back state, then the digest transactions
   localparam int DrainCycles   = 120;
   localparam int CycleLimit    = 400000;

   // md5 starting chain, a to d
   localparam logic [31:0] START_CHAIN [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   // per-round additive constants
   localparam logic [31:0] ROUND_ADDEND [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // left-rotate amounts, one row per group of sixteen rounds
   localparam int unsigned ROTATE_AMOUNT [4][4] = '{
      '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
   };

   // one digest transaction as it should appear on the rsp_ side
   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last;
   } digest_beat_type;

   // one row of the directed table; digest is only used where typed is set
   typedef struct packed {
      logic [31:0]  word;
      logic         first;
      logic         final_flag;
      logic         typed;
      logic [127:0] digest;
   } stim_row_type;

   localparam int DirectedCount = 22;

   // first sixteen rows: the padded empty message straight out of reset, no first-word
   //   flag, so the chain must come from reset; final flag set on some early words, which
   //   the block must ignore; its digest is the well-known one for the empty string
   // remaining rows: all-ones and all-zeros words, a partial block, then a first word
   //   mid-block that throws the partial block away; the random part carries on from there
   localparam stim_row_type DIRECTED_ROWS [DirectedCount] = '{
      '{32'h00000080, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b1, 1'b1,
        128'hd98c1dd4_04b2008f_980980e9_7e42f8ec},
      '{32'hffffffff, 1'b1, 1'b0, 1'b0, 128'h0},
      '{32'hffffffff, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0, 128'h0},
      '{32'ha5a5a5a5, 1'b0, 1'b1, 1'b0, 128'h0},
      '{32'h5a5a5a5a, 1'b1, 1'b1, 1'b0, 128'h0},
      '{32'hffffffff, 1'b0, 1'b0, 1'b0, 128'h0}
   };

   // clock, reset and dut ports; the driven ones are all known from time zero
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [31:0] req_message_word = '0;
   logic        req_first_word   = 1'b0;
   logic        req_final_block  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last;

   // predictor state: chaining words, block buffer and fill position
   logic [31:0] chain_words [4];
   logic [31:0] block_words [16];
   logic [3:0]  fill_position;

   // digest transactions owed by the dut, oldest first
   digest_beat_type owed_beats [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int random_words  = 0;
   bit gapless       = 1'b0;
   int stall_left    = 0;
   int calm_left     = 0;

   md5_block_hash dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .req_first_word   (req_first_word),
      .req_final_block  (req_final_block),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last         (rsp_last)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // one 64-round md5 compression of the buffered block into the chain
   function automatic void compress_chain();
      logic [31:0] a, b, c, d, f, t, rotated;
      int unsigned g, amount;
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            f = (b & c) | (~b & d);
            g = r;
         end else if (r < 32) begin
            f = (d & b) | (~d & c);
            g = 5 * r + 1;
         end else if (r < 48) begin
            f = b ^ c ^ d;
            g = 3 * r + 5;
         end else begin
            f = c ^ (b | ~d);
            g = 7 * r;
         end
         t       = f + a + ROUND_ADDEND[r] + block_words[g % 16];
         amount  = ROTATE_AMOUNT[r / 16][r % 4];
         rotated = (t << amount) | (t >> (32 - amount));
         a = d;
         d = c;
         c = b;
         b = b + rotated;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endfunction

   // takes one message word; returns 1 when a digest falls due
   function automatic bit absorb_word(input logic [31:0] word, input logic first,
                                      input logic final_flag);
      if (first) begin
         chain_words   = START_CHAIN;
         fill_position = '0;
      end
      block_words[fill_position] = word;
      if (fill_position != 4'd15) begin
         fill_position = fill_position + 4'd1;
         return 1'b0;
      end
      fill_position = '0;
      compress_chain();
      return final_flag;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 85) return $urandom_range(3, 1);
      if (p < 97) return $urandom_range(15, 4);
      return $urandom_range(80, 30);
   endfunction

   function automatic logic [31:0] pick_word();
      int p;
      p = $urandom_range(99);
      if (p < 70) return $urandom;
      if (p < 80) return 32'h0;
      if (p < 90) return 32'hffffffff;
      return 32'h1 << $urandom_range(31);
   endfunction

   // offers one message word, waits for the transaction, then books any digest it owes
   task automatic offer_word(input logic [31:0] word, input logic first,
                             input logic final_flag, input logic typed,
                             input logic [127:0] typed_digest);
      digest_beat_type beat;
      int gap;
      req_valid        <= 1'b1;
      req_message_word <= word;
      req_first_word   <= first;
      req_final_block  <= final_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (absorb_word(word, first, final_flag)) begin
         for (int k = 0; k < 4; k++) begin
            beat.digest_word = typed ? typed_digest[127 - 32 * k -: 32] : chain_words[k];
            beat.word_index  = 2'(k);
            beat.last        = (k == 3);
            owed_beats.push_back(beat);
         end
      end
      gap = gapless ? 0 : pick_gap();
      if (gap > 0) begin
         // junk on the idle bus must not be taken
         req_valid        <= 1'b0;
         req_message_word <= $urandom;
         req_first_word   <= 1'($urandom);
         req_final_block  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // one random message: mostly whole blocks with random content,
   // sometimes chained onto the previous digest, sometimes a broken partial block
   task automatic send_message();
      int kind, blocks, partial;
      bit chained;
      logic fin;
      kind    = $urandom_range(99);
      gapless = ($urandom_range(99) < 25);
      if (kind < 8) begin
         // abandoned message: the next first word must drop it
         partial = $urandom_range(15, 1);
         for (int i = 0; i < partial; i++) begin
            offer_word(pick_word(), i == 0, 1'($urandom), 1'b0, '0);
            random_words++;
         end
         return;
      end
      blocks  = (kind < 70) ? 1 : $urandom_range(3, 2);
      chained = ($urandom_range(99) < 12);
      for (int b = 0; b < blocks; b++) begin
         for (int i = 0; i < 16; i++) begin
            if (i == 15)
               fin = (b == blocks - 1);
            else
               fin = (b == blocks - 1) ? ($urandom_range(99) < 80) : 1'($urandom);
            offer_word(pick_word(), (b == 0) && (i == 0) && !chained, fin, 1'b0, '0);
            random_words++;
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      chain_words   = START_CHAIN;
      fill_position = '0;
      foreach (block_words[i]) block_words[i] = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // directed table first
      for (int row = 0; row < DirectedCount; row++) begin
         offer_word(DIRECTED_ROWS[row].word, DIRECTED_ROWS[row].first,
                    DIRECTED_ROWS[row].final_flag, DIRECTED_ROWS[row].typed,
                    DIRECTED_ROWS[row].digest);
      end

      // random messages until enough words have gone through
      while (random_words < RandomWords)
         send_message();

      req_valid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
      // a compression still in flight must not turn into a stray digest
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // digest side: random back-pressure with calm stretches, and the check of each transaction
   always @(posedge clock) begin
      digest_beat_type owed;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         calm_left  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected digest transaction word %h index %0d",
                                         rsp_digest_word, rsp_word_index));
            end else begin
               owed = owed_beats.pop_front();
               if (rsp_digest_word !== owed.digest_word)
                  report_mismatch($sformatf("digest_word %h, predicted %h (index %0d)",
                                            rsp_digest_word, owed.digest_word,
                                            owed.word_index));
               if (rsp_word_index !== owed.word_index)
                  report_mismatch($sformatf("word_index %0d, predicted %0d",
                                            rsp_word_index, owed.word_index));
               if (rsp_last !== owed.last)
                  report_mismatch($sformatf("last %b, predicted %b (index %0d)",
                                            rsp_last, owed.last, owed.word_index));
            end
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (calm_left > 0) begin
            rsp_ready <= 1'b1;
            calm_left <= calm_left - 1;
         end else if ($urandom_range(99) < 5) begin
            rsp_ready <= 1'b1;
            calm_left <= $urandom_range(200, 50);
         end else if ($urandom_range(99) < 30) begin
            rsp_ready  <= 1'b0;
            stall_left <= pick_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[%0t] timeout with %0d digest transactions outstanding",
                  $realtime, owed_beats.size());
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
